/* src/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and codes for the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_FIRE    = 2'd1,
    KIND_SUMMARY = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  localparam logic [31:0] TIMEOUT_CEILING = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  task_id;
    logic [31:0] start_time;
    logic [31:0] reload_time;
    logic        urgent;
    logic [31:0] elapsed;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [7:0]  fired_id;
    logic        deferred;
    logic [31:0] remaining;
    logic [4:0]  active_count;
    logic [31:0] least_remaining;
    logic        last;
  } rsp_item_t;

endpackage

/* src/stt_cmd_if.sv */
// ----------------------------------------------------------------------------
// stt_cmd_if
// Command channel: valid/ready with one command item.
// ----------------------------------------------------------------------------
interface stt_cmd_if;
  logic               valid;
  logic               ready;
  stt_pkg::cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/stt_rsp_if.sv */
// ----------------------------------------------------------------------------
// stt_rsp_if
// Result channel: valid/ready with one result item.
// ----------------------------------------------------------------------------
interface stt_rsp_if;
  logic               valid;
  logic               ready;
  stt_pkg::rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/software_timer_table.sv */
// Sequence: stop, query and tick make one ring rotation from acceptance to the last result;
// start makes one ring rotation to search and a second to write and total up.
// Commands are taken only in idle, after the previous closing result; the ring rotates
// one slot per cycle via the single head unit; the walk stalls while a result waits.
// Reset (synchronous, rst high) empties every slot and returns the controller to idle.
// ----------------------------------------------------------------------------
// software_timer_table
// Table of timer slots held in a rotating ring of cells, processed at the head.
// ----------------------------------------------------------------------------
module software_timer_table #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  stt_cmd_if.sink    cmd,
  stt_rsp_if.source  rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_REPLY  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Captured command
  logic [1:0]         op_r;
  logic [ID_BITS-1:0] id_r;
  logic [31:0]        t0_r, rl_r, el_r;
  logic               urg_r;

  logic [IDX_W-1:0] step;
  logic             step_last;

  // Search results
  logic             match_found, free_found;
  logic [IDX_W-1:0] match_idx, free_idx;
  logic             full;
  logic [IDX_W-1:0] target;

  // Walk accumulators
  logic        found;
  logic [31:0] qrem;
  logic [4:0]  cnt;
  logic        any_used;
  logic [31:0] least;

  // Ring
  logic [SLOTS-1:0]   c_used, c_live, c_urgent;
  logic [ID_BITS-1:0] c_owner [SLOTS];
  logic [31:0]        c_rem [SLOTS];
  logic [31:0]        c_per [SLOTS];

  logic               n_used, n_live, n_urgent;
  logic [ID_BITS-1:0] n_owner;
  logic [31:0]        n_rem, n_per;
  logic               shift, hit, fire, can_emit;
  logic [31:0]        dec;

  logic               ov;
  stt_pkg::rsp_item_t od;

  assign cmd.ready = (state == ST_IDLE) && !rst;
  assign rsp.valid = ov;
  assign rsp.data  = od;
  assign can_emit  = !ov || rsp.ready;
  assign step_last = (step == IDX_W'(SLOTS - 1));
  assign full      = !match_found && !free_found;
  assign target    = match_found ? match_idx : free_idx;
  assign hit       = c_used[0] && (c_owner[0] == id_r);

  // Build the ring: each cell takes its upper neighbour, the top takes the head result
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_top
      stt_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk(clk), .rst(rst), .shift(shift),
        .d_used(n_used), .d_owner(n_owner), .d_remaining(n_rem),
        .d_period(n_per), .d_live(n_live), .d_urgent(n_urgent),
        .q_used(c_used[i]), .q_owner(c_owner[i]), .q_remaining(c_rem[i]),
        .q_period(c_per[i]), .q_live(c_live[i]), .q_urgent(c_urgent[i])
      );
    end else begin : g_mid
      stt_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk(clk), .rst(rst), .shift(shift),
        .d_used(c_used[i+1]), .d_owner(c_owner[i+1]), .d_remaining(c_rem[i+1]),
        .d_period(c_per[i+1]), .d_live(c_live[i+1]), .d_urgent(c_urgent[i+1]),
        .q_used(c_used[i]), .q_owner(c_owner[i]), .q_remaining(c_rem[i]),
        .q_period(c_per[i]), .q_live(c_live[i]), .q_urgent(c_urgent[i])
      );
    end
  end

  // Head unit: update the slot at the head of the ring
  always_comb begin
    n_used   = c_used[0];
    n_owner  = c_owner[0];
    n_rem    = c_rem[0];
    n_per    = c_per[0];
    n_live   = c_live[0];
    n_urgent = c_urgent[0];
    fire     = 1'b0;
    dec      = (c_rem[0] <= el_r) ? 32'd0 : c_rem[0] - el_r;
    shift    = (state == ST_SEARCH) || ((state == ST_WALK) && can_emit);
    if (state == ST_WALK) begin
      case (op_r)
        stt_pkg::OP_START: begin
          if (!full && step == target) begin
            n_used   = 1'b1;
            n_owner  = id_r;
            n_rem    = t0_r;
            n_per    = rl_r;
            n_live   = 1'b1;
            n_urgent = urg_r;
          end
        end
        stt_pkg::OP_STOP: begin
          if (hit) begin
            n_live = 1'b0;
          end
        end
        stt_pkg::OP_TICK: begin
          if (c_used[0]) begin
            fire  = (dec == 32'd0);
            n_rem = (fire && c_per[0] != 32'd0 && c_live[0]) ? c_per[0] : dec;
            if (n_rem == 32'd0 || !c_live[0]) begin
              n_used = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.data.op == stt_pkg::OP_START) ? ST_SEARCH : ST_WALK;
        end
      end
      ST_SEARCH: if (step_last) state_next = ST_WALK;
      ST_WALK:   if (shift && step_last) state_next = ST_REPLY;
      ST_REPLY:  if (can_emit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE || state_next != state) begin
        step <= '0;
      end else if (shift) begin
        step <= step + IDX_W'(1);
      end
    end
  end

  // Capture command, run search and walk accumulators
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_r        <= cmd.data.op;
      id_r        <= ID_BITS'(cmd.data.task_id);
      t0_r        <= cmd.data.start_time;
      rl_r        <= cmd.data.reload_time;
      urg_r       <= cmd.data.urgent;
      el_r        <= cmd.data.elapsed;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      match_idx   <= '0;
      free_idx    <= '0;
      found       <= 1'b0;
      qrem        <= 32'd0;
      cnt         <= 5'd0;
      any_used    <= 1'b0;
      least       <= stt_pkg::TIMEOUT_CEILING;
    end else if (state == ST_SEARCH) begin
      if (hit && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= step;
      end
      if (!c_used[0] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= step;
      end
    end else if (state == ST_WALK && shift) begin
      if (hit && op_r != stt_pkg::OP_TICK) begin
        found <= 1'b1;
        qrem  <= c_rem[0];
      end
      if (n_used) begin
        cnt      <= cnt + 5'd1;
        any_used <= 1'b1;
        if (n_rem < least) least <= n_rem;
      end
    end
  end

  // Output register: fire results during the walk, closing result after it
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == ST_WALK && shift && fire) begin
      ov <= 1'b1;
    end else if (state == ST_REPLY && can_emit) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WALK && shift && fire) begin
      od.kind            <= stt_pkg::KIND_FIRE;
      od.status          <= 1'b0;
      od.fired_id        <= 8'(c_owner[0]);
      od.deferred        <= !c_urgent[0];
      od.remaining       <= 32'd0;
      od.active_count    <= 5'd0;
      od.least_remaining <= 32'd0;
      od.last            <= 1'b0;
    end else if (state == ST_REPLY && can_emit) begin
      od.kind            <= (op_r == stt_pkg::OP_TICK) ? stt_pkg::KIND_SUMMARY
                                                       : stt_pkg::KIND_REPLY;
      od.status          <= (op_r == stt_pkg::OP_START) ? full :
                            (op_r == stt_pkg::OP_TICK)  ? 1'b0 : !found;
      od.fired_id        <= 8'd0;
      od.deferred        <= 1'b0;
      od.remaining       <= (op_r == stt_pkg::OP_QUERY) ? qrem : 32'd0;
      od.active_count    <= cnt;
      od.least_remaining <= any_used ? least : 32'd0;
      od.last            <= 1'b1;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command taken while previous item in flight");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.kind == stt_pkg::KIND_FIRE |-> !rsp.data.last)
    else $error("fire result marked last");

  a_empty_least_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.last && rsp.data.active_count == 5'd0 && SLOTS < 32
      |-> rsp.data.least_remaining == 32'd0)
    else $error("empty table reports nonzero least time");

  a_fire_only_in_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) && od.kind == stt_pkg::KIND_FIRE |-> $past(state) == ST_WALK)
    else $error("fire result outside tick walk");

endmodule

/* src/stt_cell.sv */
// ----------------------------------------------------------------------------
// stt_cell
// One timer slot of the ring; loads its neighbour's slot on every shift.
// ----------------------------------------------------------------------------
module stt_cell #(
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  logic               d_used,
  input  logic [ID_BITS-1:0] d_owner,
  input  logic [31:0]        d_remaining,
  input  logic [31:0]        d_period,
  input  logic               d_live,
  input  logic               d_urgent,
  output logic               q_used,
  output logic [ID_BITS-1:0] q_owner,
  output logic [31:0]        q_remaining,
  output logic [31:0]        q_period,
  output logic               q_live,
  output logic               q_urgent
);

  // Occupancy flag is the only state cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q_used <= 1'b0;
    end else if (shift) begin
      q_used <= d_used;
    end
  end

  // Slot contents move with the ring
  always_ff @(posedge clk) begin
    if (shift) begin
      q_owner     <= d_owner;
      q_remaining <= d_remaining;
      q_period    <= d_period;
      q_live      <= d_live;
      q_urgent    <= d_urgent;
    end
  end

endmodule
